[design/dlts_pkg.sv]
// Shared types and codes for the delta-list task scheduler.
`timescale 1ns / 1ps

package dlts_pkg;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_DISPATCHED = 2'd2;
    localparam logic [1:0] STATUS_NOTHING    = 2'd3;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] ticks;
        logic [15:0] period;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_T_HEAD,
        ST_T_SWEEP,
        ST_A_START,
        ST_A_SCAN,
        ST_A_PUT,
        ST_D_HEAD,
        ST_D_SHIFT
    } state_t;

endpackage

[design/dlts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dlts_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/delta_list_task_scheduler_top.sv]
// Top level of the delta-list task scheduler: sequencer around one entry RAM.
//
//  channel  | signals                                            | handshake
//  ---------+----------------------------------------------------+-------------------
//  command  | opcode, task_ident, first_delay, repeat_period     | start && !busy
//  result   | status, due_task_ident, tasks_held                 | done, one cycle
//
//  Entries live in one RAM, sorted by ticks left.
//  Tick: table left as is when empty or when the head is due, else every entry counts down by one.
//  Add: FULL when full, else put after every entry with no more ticks, scanning from the tail.
//  Dispatch: NOTHING when empty or the head is not due, else pops the head, shifts the rest
//  down and adds it back with its period as its delay when that period is nonzero.
//  Reset clears the count and control state only; no clearing pass is needed.
//  The result strobe cannot be stalled; busy drops in the cycle done is high.
`timescale 1ns / 1ps

module delta_list_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  task_ident,
    input  logic [15:0] first_delay,
    input  logic [15:0] repeat_period,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  due_task_ident,
    output logic [4:0]  tasks_held
);

    localparam int AW    = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    dlts_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    dlts_pkg::entry_t ent_reg, ent_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       due_reg, due_next;
    logic             done_reg, done_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    dlts_pkg::entry_t ram_wdata;
    logic [AW-1:0]    ram_raddr;
    dlts_pkg::entry_t ram_rdata;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W+4:0] count_ext;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign count_ext = {5'd0, count_reg};

    dlts_ram #(
        .WIDTH ($bits(dlts_pkg::entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dlts_pkg::ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= dlts_pkg::STATUS_DONE;
            due_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            due_reg    <= due_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ent_next    = ent_reg;
        status_next = status_reg;
        due_next    = due_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[AW-1:0];

        unique case (state_reg)
            dlts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    status_next     = dlts_pkg::STATUS_DONE;
                    due_next        = '0;
                    ent_next.ident  = task_ident;
                    ent_next.ticks  = first_delay;
                    ent_next.period = repeat_period;
                    unique case (opcode)
                        dlts_pkg::OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = dlts_pkg::ST_T_HEAD;
                            end
                        end
                        dlts_pkg::OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_TASKS))
                            begin
                                status_next = dlts_pkg::STATUS_FULL;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = '0;
                                ram_wdata.ident  = task_ident;
                                ram_wdata.ticks  = first_delay;
                                ram_wdata.period = repeat_period;
                                count_next       = count_reg + CNT_W'(1);
                                done_next        = 1'b1;
                            end
                            else
                            begin
                                state_next = dlts_pkg::ST_A_START;
                            end
                        end
                        dlts_pkg::OP_DISPATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = dlts_pkg::STATUS_NOTHING;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = dlts_pkg::ST_D_HEAD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            dlts_pkg::ST_T_HEAD:
            begin
                if (ram_rdata.ticks == '0)
                begin
                    done_next  = 1'b1;
                    state_next = dlts_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = dlts_pkg::ST_T_SWEEP;
                end
            end

            dlts_pkg::ST_T_SWEEP:
            begin
                ram_we          = 1'b1;
                ram_wdata.ticks = ram_rdata.ticks - 16'd1;
                if (idx_reg == count_dec)
                begin
                    done_next  = 1'b1;
                    state_next = dlts_pkg::ST_IDLE;
                end
                else
                begin
                    ram_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc;
                end
            end

            dlts_pkg::ST_A_START:
            begin
                ram_raddr  = count_dec[AW-1:0];
                idx_next   = count_dec;
                state_next = dlts_pkg::ST_A_SCAN;
            end

            dlts_pkg::ST_A_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_inc[AW-1:0];
                if (ram_rdata.ticks > ent_reg.ticks)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = dlts_pkg::ST_A_PUT;
                    end
                    else
                    begin
                        ram_raddr = idx_dec[AW-1:0];
                        idx_next  = idx_dec;
                    end
                end
                else
                begin
                    ram_wdata  = ent_reg;
                    count_next = count_reg + CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = dlts_pkg::ST_IDLE;
                end
            end

            dlts_pkg::ST_A_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = ent_reg;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = dlts_pkg::ST_IDLE;
            end

            dlts_pkg::ST_D_HEAD:
            begin
                if (ram_rdata.ticks != '0)
                begin
                    status_next = dlts_pkg::STATUS_NOTHING;
                    done_next   = 1'b1;
                    state_next  = dlts_pkg::ST_IDLE;
                end
                else
                begin
                    status_next     = dlts_pkg::STATUS_DISPATCHED;
                    due_next        = ram_rdata.ident;
                    ent_next.ident  = ram_rdata.ident;
                    ent_next.ticks  = ram_rdata.period;
                    ent_next.period = ram_rdata.period;
                    if (count_reg == CNT_W'(1))
                    begin
                        count_next = '0;
                        if (ram_rdata.period != '0)
                        begin
                            state_next = dlts_pkg::ST_A_PUT;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = dlts_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        ram_raddr  = AW'(1);
                        idx_next   = CNT_W'(1);
                        state_next = dlts_pkg::ST_D_SHIFT;
                    end
                end
            end

            dlts_pkg::ST_D_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_dec[AW-1:0];
                if (idx_reg == count_dec)
                begin
                    count_next = count_dec;
                    if (ent_reg.period != '0)
                    begin
                        state_next = dlts_pkg::ST_A_START;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = dlts_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ram_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc;
                end
            end

            default:
            begin
                state_next = dlts_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != dlts_pkg::ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign due_task_ident = due_reg;
    assign tasks_held     = count_ext[4:0];

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == dlts_pkg::ST_IDLE)
        else $error("result strobe outside idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above table size");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == dlts_pkg::STATUS_FULL |-> count_reg == CNT_W'(MAX_TASKS))
        else $error("add refused while table has room");

    a_due_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != dlts_pkg::STATUS_DISPATCHED |-> due_reg == '0)
        else $error("due id set without dispatch");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done_reg)
        else $error("accepted transaction dropped");

endmodule

[bench/tb_delta_list_task_scheduler_top.sv]
// Self-checking testbench for the delta-list task scheduler top level.
`timescale 1ns / 1ps

module tb_delta_list_task_scheduler_top;

    localparam int TASK_SLOTS    = 16;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int CALM_ITEMS    = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PERIODIC_CAP  = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] due_ident;
        logic [4:0] held;
    } report_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ident;
        logic [15:0] delay;
        logic [15:0] period;
        int          reps;
        logic        fixed;
        report_t     report;
    } step_row_t;

    localparam int PLAN_ROWS = 20;
    localparam step_row_t PLAN [PLAN_ROWS] = '{
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_NOTHING, 8'h00, 5'd0}},
        '{dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{OP_UNUSED,             8'hFF, 16'hFFFF, 16'hFFFF, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{dlts_pkg::OP_ADD,      8'hFF, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd1}},
        '{dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd1}},
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DISPATCHED, 8'hFF, 5'd0}},
        '{dlts_pkg::OP_ADD,      8'h00, 16'hFFFF, 16'hFFFF, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd1}},
        '{dlts_pkg::OP_ADD,      8'hA5, 16'h0001, 16'h0003, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd2}},
        '{dlts_pkg::OP_ADD,      8'h5A, 16'h0001, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd3}},
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_NOTHING, 8'h00, 5'd3}},
        '{dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd3}},
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DISPATCHED, 8'hA5, 5'd3}},
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_DISPATCHED, 8'h5A, 5'd2}},
        '{dlts_pkg::OP_ADD,      8'h10, 16'h0002, 16'h0001, 14, 1'b0,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{dlts_pkg::OP_ADD,      8'h77, 16'h0000, 16'h0000, 1, 1'b1,
          '{dlts_pkg::STATUS_FULL, 8'h00, 5'd16}},
        '{dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 1, 1'b0,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 1, 1'b0,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b0,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 1, 1'b0,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}},
        '{dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000, 1, 1'b0,
          '{dlts_pkg::STATUS_DONE, 8'h00, 5'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  task_ident;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  due_task_ident;
    logic [4:0]  tasks_held;

    logic        fixed_valid;
    report_t     fixed_report;

    logic [7:0]  slot_ident  [TASK_SLOTS];
    logic [15:0] slot_ticks  [TASK_SLOTS];
    logic [15:0] slot_period [TASK_SLOTS];
    int          slot_count = 0;

    report_t status_reports [$];
    int      error_count    = 0;
    int      accepted_items = 0;
    int      quiet_cycles   = 0;

    delta_list_task_scheduler_top #(
        .MAX_TASKS(TASK_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .task_ident(task_ident),
        .first_delay(first_delay),
        .repeat_period(repeat_period),
        .done(done),
        .status(status),
        .due_task_ident(due_task_ident),
        .tasks_held(tasks_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void place_task(input logic [7:0] ident, input logic [15:0] ticks,
                                       input logic [15:0] period);
        int pos;
        int k;
        pos = 0;
        while (pos < slot_count && slot_ticks[pos] <= ticks)
            pos++;
        for (k = slot_count; k > pos; k--)
        begin
            slot_ident[k]  = slot_ident[k - 1];
            slot_ticks[k]  = slot_ticks[k - 1];
            slot_period[k] = slot_period[k - 1];
        end
        slot_ident[pos]  = ident;
        slot_ticks[pos]  = ticks;
        slot_period[pos] = period;
        slot_count++;
    endfunction

    function automatic report_t schedule_op(input logic [1:0] op, input logic [7:0] ident,
                                            input logic [15:0] delay,
                                            input logic [15:0] period);
        report_t     r;
        logic [7:0]  head_ident;
        logic [15:0] head_period;
        int          k;
        r.status    = dlts_pkg::STATUS_DONE;
        r.due_ident = 8'h00;
        case (op)
            dlts_pkg::OP_TICK:
            begin
                if (slot_count > 0 && slot_ticks[0] != 16'd0)
                    for (k = 0; k < slot_count; k++)
                        slot_ticks[k] = slot_ticks[k] - 16'd1;
            end
            dlts_pkg::OP_ADD:
            begin
                if (slot_count >= TASK_SLOTS)
                    r.status = dlts_pkg::STATUS_FULL;
                else
                    place_task(ident, delay, period);
            end
            dlts_pkg::OP_DISPATCH:
            begin
                if (slot_count > 0 && slot_ticks[0] == 16'd0)
                begin
                    head_ident  = slot_ident[0];
                    head_period = slot_period[0];
                    for (k = 0; k + 1 < slot_count; k++)
                    begin
                        slot_ident[k]  = slot_ident[k + 1];
                        slot_ticks[k]  = slot_ticks[k + 1];
                        slot_period[k] = slot_period[k + 1];
                    end
                    slot_count--;
                    if (head_period != 16'd0)
                        place_task(head_ident, head_period, head_period);
                    r.status    = dlts_pkg::STATUS_DISPATCHED;
                    r.due_ident = head_ident;
                end
                else
                begin
                    r.status = dlts_pkg::STATUS_NOTHING;
                end
            end
            default:
            begin
            end
        endcase
        r.held = 5'(slot_count);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        report_t want;
        report_t model;
        if (rst_n)
        begin
            quiet_cycles++;
            if (done)
            begin
                quiet_cycles = 0;
                if (status_reports.size() == 0)
                begin
                    $display("%0t: unexpected transaction: status %0d ident %0d held %0d",
                             $time, status, due_task_ident, tasks_held);
                    error_count++;
                end
                else
                begin
                    want = status_reports.pop_front();
                    check_field("status", 8'(want.status), 8'(status));
                    check_field("due_task_ident", want.due_ident, due_task_ident);
                    check_field("tasks_held", 8'(want.held), 8'(tasks_held));
                end
            end
            if (start && !busy)
            begin
                quiet_cycles = 0;
                model = schedule_op(opcode, task_ident, first_delay, repeat_period);
                status_reports.push_back(fixed_valid ? fixed_report : model);
                accepted_items++;
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("simulation failed");
        $finish;
    end

    task automatic send_op(input logic [1:0] op, input logic [7:0] ident,
                           input logic [15:0] delay, input logic [15:0] period,
                           input logic fixed, input report_t report, input bit gaps);
        int seen;
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        opcode        <= op;
        task_ident    <= ident;
        first_delay   <= delay;
        repeat_period <= period;
        fixed_valid   <= fixed;
        fixed_report  <= report;
        start         <= 1'b1;
        seen = accepted_items;
        do
            @(negedge clk);
        while (accepted_items == seen);
    endtask

    initial
    begin : stimulus
        int          i;
        int          k;
        int          pick;
        bit          filling;
        logic [1:0]  op;
        logic [7:0]  ident;
        logic [15:0] delay;
        logic [15:0] period;
        start         = 1'b0;
        opcode        = dlts_pkg::OP_TICK;
        task_ident    = 8'h00;
        first_delay   = 16'h0000;
        repeat_period = 16'h0000;
        fixed_valid   = 1'b0;
        fixed_report  = '0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < PLAN_ROWS; i++)
            for (k = 0; k < PLAN[i].reps; k++)
                send_op(PLAN[i].op, PLAN[i].ident + 8'(k), PLAN[i].delay + 16'(k % 3),
                        PLAN[i].period, PLAN[i].fixed, PLAN[i].report, 1'b1);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            filling = ((i / 120) % 2) == 0;
            pick    = $urandom_range(0, 99);
            ident   = 8'($urandom);
            delay   = 16'($urandom);
            period  = 16'($urandom);
            if (pick < 4)
            begin
                op = OP_UNUSED;
            end
            else if (pick < (filling ? 55 : 20))
            begin
                op = dlts_pkg::OP_ADD;
                if ($urandom_range(0, 6) == 0)
                    delay = 16'($urandom_range(7, 40));
                else
                    delay = 16'($urandom_range(0, 6));
                pick = $urandom_range(0, 9);
                if (slot_count >= PERIODIC_CAP || pick < 4)
                    period = 16'd0;
                else if (pick < 9)
                    period = 16'($urandom_range(1, 8));
                else
                    period = 16'($urandom_range(9, 60));
            end
            else if (pick < (filling ? 75 : 60))
            begin
                op = dlts_pkg::OP_TICK;
            end
            else
            begin
                op = dlts_pkg::OP_DISPATCH;
            end
            send_op(op, ident, delay, period, 1'b0, '0,
                    (i < RANDOM_ITEMS - CALM_ITEMS) && ((i / 100) % 3 != 2));
        end

        start <= 1'b0;
        while (status_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
